### rtl/fasta_amino_acid_composition_top_assert.svh
// Assertion macros for the amino acid composition counter.
// They expect signals named clk and rst in the module that uses them.
`ifndef FASTA_AMINO_ACID_COMPOSITION_TOP_ASSERT_SVH
`define FASTA_AMINO_ACID_COMPOSITION_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define FAAC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define FAAC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/faac_pkg.sv
package faac_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int NUM_RES            = 20;
  localparam int RES_W              = 5;
  localparam int OUT_CNT_W          = 16;

  localparam logic [RES_W-1:0] LAST_RES = RES_W'(NUM_RES - 1);

  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_NL = 8'h0A;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [RES_W-1:0]     residue_index;
    logic [OUT_CNT_W-1:0] residue_count;
    logic                 last_of_record;
  } out_item_t;

  typedef struct packed {
    logic             hit;
    logic [RES_W-1:0] slot;
  } slot_t;

  // Maps an upper-case standard residue letter to its counter slot.
  function automatic slot_t letter_slot(input logic [7:0] b);
    slot_t s;
    s.hit  = 1'b1;
    s.slot = '0;
    case (b)
      8'h41:   s.slot = RES_W'(0);   // A
      8'h43:   s.slot = RES_W'(1);   // C
      8'h44:   s.slot = RES_W'(2);   // D
      8'h45:   s.slot = RES_W'(3);   // E
      8'h46:   s.slot = RES_W'(4);   // F
      8'h47:   s.slot = RES_W'(5);   // G
      8'h48:   s.slot = RES_W'(6);   // H
      8'h49:   s.slot = RES_W'(7);   // I
      8'h4B:   s.slot = RES_W'(8);   // K
      8'h4C:   s.slot = RES_W'(9);   // L
      8'h4D:   s.slot = RES_W'(10);  // M
      8'h4E:   s.slot = RES_W'(11);  // N
      8'h50:   s.slot = RES_W'(12);  // P
      8'h51:   s.slot = RES_W'(13);  // Q
      8'h52:   s.slot = RES_W'(14);  // R
      8'h53:   s.slot = RES_W'(15);  // S
      8'h54:   s.slot = RES_W'(16);  // T
      8'h56:   s.slot = RES_W'(17);  // V
      8'h57:   s.slot = RES_W'(18);  // W
      8'h59:   s.slot = RES_W'(19);  // Y
      default: s.hit  = 1'b0;
    endcase
    return s;
  endfunction

endpackage

### rtl/fasta_amino_acid_composition_top.sv
// Amino acid composition counter for a FASTA byte stream.
// The input channel carries one item per text byte (in_valid, in_stall,
// in_data); an item with end_of_input set marks the end of the file.
// The output channel (out_valid, out_stall, out_data) carries one item
// per residue: twenty items in alphabetical letter order, the last one
// flagged with last_of_record, whenever a record with a sequence ends.
// Text bytes are taken at one per cycle while no flush is under way. The
// per-residue counters live in a small one-port-read memory; a count is
// read, then incremented and written back from the registered read data,
// with a forwarding register so that repeated letters in consecutive
// cycles still count correctly. When a record ends, the block stalls its
// input and walks the counter memory, a memory read and an output load
// per result, holding the input until the walk is done, output stalls included.
// The ending item starts the walk in S_READ; each result is registered into the output from S_SEND.
// A stalled output holds its item and the walk simply waits for it.
// Reset clears all counters at once through per-entry valid flags, and
// leaves the block outside any header with no pending sequence.
module fasta_amino_acid_composition_top
  import faac_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam int WIDE_W = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_t;

  state_t st;

  logic                  in_header;
  logic                  have_seq;
  logic [NUM_RES-1:0]    entry_ok;
  logic                  rd_ok;
  logic                  inc_valid;
  logic [RES_W-1:0]      inc_slot;
  logic                  fwd_valid;
  logic [RES_W-1:0]      fwd_slot;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [RES_W-1:0]      flush_idx;

  logic                  in_acc;
  slot_t                 sl;
  logic                  is_eoi;
  logic                  is_gt;
  logic                  is_nl;
  logic                  seq_byte;
  logic                  do_inc;
  logic                  do_flush;
  logic                  ram_re;
  logic [RES_W-1:0]      ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [COUNT_BITS-1:0] flush_cnt;
  logic [WIDE_W-1:0]     flush_wide;
  logic                  out_free;
  logic                  send_now;

  // Input decode. A sequence byte is anything outside a header that is
  // neither a record marker nor a newline; only standard letters count.
  assign in_stall = (st != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign sl       = letter_slot(in_data.in_byte);
  assign is_eoi   = in_data.end_of_input;
  assign is_gt    = (in_data.in_byte == CH_GT);
  assign is_nl    = (in_data.in_byte == CH_NL);
  assign seq_byte = !is_eoi && !in_header && !is_gt && !is_nl;
  assign do_inc   = in_acc && seq_byte && sl.hit;
  assign do_flush = in_acc && have_seq && (is_eoi || (!in_header && is_gt));

  // The memory is read by the increment path when idle and by the walk
  // during a flush; the two never overlap.
  assign ram_re    = do_inc || (st == S_READ);
  assign ram_raddr = (st == S_READ) ? flush_idx : sl.slot;

  // Second stage of the increment: take the freshest value of the slot.
  // An entry not written since its last clear reads as zero.
  always_comb begin
    if (fwd_valid && (fwd_slot == inc_slot)) begin
      cur_cnt = fwd_data;
    end else if (rd_ok) begin
      cur_cnt = ram_rdata;
    end else begin
      cur_cnt = '0;
    end
    new_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
  end

  assign flush_cnt  = rd_ok ? ram_rdata : '0;
  assign flush_wide = WIDE_W'(flush_cnt);
  assign out_free   = !out_valid || !out_stall;
  assign send_now   = (st == S_SEND) && out_free;

  faac_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_RES)
  ) u_counts (
    .clk   (clk),
    .we    (inc_valid),
    .waddr (inc_slot),
    .wdata (new_cnt),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Parser state and the increment pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_header <= 1'b0;
      have_seq  <= 1'b0;
      inc_valid <= 1'b0;
      fwd_valid <= 1'b0;
      rd_ok     <= 1'b0;
      entry_ok  <= '0;
    end else begin
      if (in_acc) begin
        if (is_eoi) begin
          in_header <= 1'b0;
        end else if (in_header) begin
          if (is_nl) begin
            in_header <= 1'b0;
          end
        end else if (is_gt) begin
          in_header <= 1'b1;
        end
      end
      if (do_flush) begin
        have_seq <= 1'b0;
      end else if (in_acc && seq_byte) begin
        have_seq <= 1'b1;
      end
      inc_valid <= do_inc;
      // The forwarding copy is only good in the cycle after its write.
      fwd_valid <= inc_valid;
      if (ram_re) begin
        rd_ok <= entry_ok[ram_raddr];
      end
      if (inc_valid) begin
        entry_ok[inc_slot] <= 1'b1;
      end
      if (send_now) begin
        entry_ok[flush_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_inc) begin
      inc_slot <= sl.slot;
    end
    if (inc_valid) begin
      fwd_slot <= inc_slot;
      fwd_data <= new_cnt;
    end
  end

  // Flush sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      out_valid <= 1'b0;
      flush_idx <= '0;
    end else begin
      if (out_valid && !out_stall && !send_now) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (do_flush) begin
            flush_idx <= '0;
            st        <= S_READ;
          end
        end
        S_READ: begin
          st <= S_SEND;
        end
        S_SEND: begin
          if (out_free) begin
            out_valid                   <= 1'b1;
            out_data.residue_index      <= flush_idx;
            out_data.residue_count      <= flush_wide[OUT_CNT_W-1:0];
            out_data.last_of_record     <= (flush_idx == LAST_RES);
            if (flush_idx == LAST_RES) begin
              st <= S_IDLE;
            end else begin
              flush_idx <= flush_idx + 1'b1;
              st        <= S_READ;
            end
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  `include "fasta_amino_acid_composition_top_assert.svh"

  `FAAC_ASSERT_IMPLIES(a_last_is_y, out_valid && out_data.last_of_record,
                       out_data.residue_index == LAST_RES,
                       "last_of_record on a residue other than the last")
  `FAAC_ASSERT_IMPLIES(a_inc_not_in_flush, inc_valid, st == S_IDLE,
                       "counter update overlaps a flush walk")
  `FAAC_ASSERT_ALWAYS(a_walk_in_range, (st == S_IDLE) || (flush_idx <= LAST_RES),
                      "flush walk index out of range")

endmodule

### rtl/faac_ram.sv
module faac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
